// ===== rtl/core/tsa_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tsa_pkg
// Shared types, constants and helpers of the transport stream packet aligner.
// ============================================================================
package tsa_pkg;

    localparam int HISTORY_DEPTH_DEFAULT = 512;

    localparam logic [7:0] SYNC_BYTE        = 8'h47;
    localparam int         OUT_PACKET_BYTES = 188;

    localparam int SIZE_188 = 188;
    localparam int SIZE_192 = 192;
    localparam int SIZE_204 = 204;

    localparam int LAG_192 = SIZE_192 - SIZE_188;
    localparam int LAG_204 = SIZE_204 - SIZE_188;
    localparam int TAP_LEN = LAG_204;

    localparam int NUM_SIZES = 3;

    typedef enum logic [1:0] {
        SZ_188 = 2'd0,
        SZ_192 = 2'd1,
        SZ_204 = 2'd2
    } size_code_t;

    typedef enum logic {
        REG_CONFIRM_COUNT = 1'b0,
        REG_SIZE_ENABLE   = 1'b1
    } reg_index_t;

    typedef enum logic {
        ST_HUNT = 1'b0,
        ST_LOCK = 1'b1
    } lock_state_t;

    typedef struct packed {
        logic c204;
        logic c192;
        logic c188;
        logic sync;
    } hist_word_t;

    typedef struct packed {
        logic [NUM_SIZES-1:0] one_back;
        logic [NUM_SIZES-1:0] two_back;
    } sync_hits_t;

    typedef struct packed {
        logic       first_of_packet;
        logic       last_of_packet;
        size_code_t size_code;
        logic [7:0] out_byte;
    } out_word_t;

    function automatic logic [7:0] packet_bytes(input size_code_t code);
        logic [7:0] n;
        unique case (code)
            SZ_188:  n = 8'(SIZE_188);
            SZ_192:  n = 8'(SIZE_192);
            SZ_204:  n = 8'(SIZE_204);
            default: n = 8'(SIZE_188);
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/core/tsa_history.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tsa_history
// Sync history memory with a 188-byte read lag and a short tap line for the
// 192 and 204 spacings; each word also carries the one-back hits.
// ============================================================================
module tsa_history #(
    parameter int HISTORY_DEPTH = tsa_pkg::HISTORY_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                clear,
    input  logic                is_sync,
    output tsa_pkg::sync_hits_t hits
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [PTR_W-1:0] LAG       = PTR_W'(tsa_pkg::SIZE_188);
    localparam logic [PTR_W-1:0] WRAP_LAG  = PTR_W'(HISTORY_DEPTH - tsa_pkg::SIZE_188);
    localparam logic [7:0]       FILL_MAX  = 8'(tsa_pkg::SIZE_188);

    tsa_pkg::hist_word_t mem [HISTORY_DEPTH];
    tsa_pkg::hist_word_t rd_data_reg;
    tsa_pkg::hist_word_t lagged;
    tsa_pkg::hist_word_t wr_word;
    tsa_pkg::hist_word_t tap_reg [1:tsa_pkg::TAP_LEN];

    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [PTR_W-1:0] rd_addr;
    logic [7:0]       fill_reg;
    logic [7:0]       fill_next;

    always_comb
    begin
        ptr_next  = ptr_reg;
        fill_next = fill_reg;
        if (clear)
        begin
            ptr_next  = '0;
            fill_next = '0;
        end
        else if (step)
        begin
            ptr_next = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;
            if (fill_reg != FILL_MAX)
            begin
                fill_next = fill_reg + 8'd1;
            end
        end
        rd_addr = (ptr_next >= LAG) ? ptr_next - LAG : ptr_next + WRAP_LAG;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && !clear)
        begin
            mem[ptr_reg] <= wr_word;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        lagged = (fill_reg == FILL_MAX) ? rd_data_reg : '0;

        hits.one_back[tsa_pkg::SZ_188] = lagged.sync;
        hits.one_back[tsa_pkg::SZ_192] = tap_reg[tsa_pkg::LAG_192].sync;
        hits.one_back[tsa_pkg::SZ_204] = tap_reg[tsa_pkg::LAG_204].sync;
        hits.two_back[tsa_pkg::SZ_188] = lagged.c188;
        hits.two_back[tsa_pkg::SZ_192] = tap_reg[tsa_pkg::LAG_192].c192;
        hits.two_back[tsa_pkg::SZ_204] = tap_reg[tsa_pkg::LAG_204].c204;

        wr_word.sync = is_sync;
        wr_word.c188 = is_sync && hits.one_back[tsa_pkg::SZ_188];
        wr_word.c192 = is_sync && hits.one_back[tsa_pkg::SZ_192];
        wr_word.c204 = is_sync && hits.one_back[tsa_pkg::SZ_204];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= tsa_pkg::TAP_LEN; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else if (clear)
        begin
            for (int i = 1; i <= tsa_pkg::TAP_LEN; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            tap_reg[1] <= lagged;
            for (int i = 2; i <= tsa_pkg::TAP_LEN; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

endmodule

// ===== rtl/core/tsa_framer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tsa_framer
// Lock control, packet position and configuration registers; picks the
// packet size on a confirmed sync byte and forms each output word.
// ============================================================================
module tsa_framer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                clear,
    input  logic                is_sync,
    input  logic [7:0]          data_byte,
    input  tsa_pkg::sync_hits_t hits,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [2:0]          cfg_data,
    output logic                produce,
    output tsa_pkg::out_word_t  word
);

    tsa_pkg::lock_state_t state_reg;
    tsa_pkg::lock_state_t state_next;
    tsa_pkg::size_code_t  size_reg;
    tsa_pkg::size_code_t  size_next;
    tsa_pkg::size_code_t  found_size;
    tsa_pkg::size_code_t  cur_size;
    logic [7:0]           pos_reg;
    logic [7:0]           pos_next;
    logic [7:0]           cur_pos;
    logic [8:0]           pos_inc;
    logic [1:0]           confirm_reg;
    logic [2:0]           enable_reg;
    logic [2:0]           size_ok;
    logic                 found;
    logic                 lost;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_reg <= 2'd2;
            enable_reg  <= 3'd7;
        end
        else if (cfg_write)
        begin
            unique case (tsa_pkg::reg_index_t'(cfg_index))
                tsa_pkg::REG_CONFIRM_COUNT: confirm_reg <= cfg_data[1:0];
                tsa_pkg::REG_SIZE_ENABLE:   enable_reg  <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsa_pkg::ST_HUNT;
            size_reg  <= tsa_pkg::SZ_188;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            pos_reg   <= pos_next;
        end
    end

    always_comb
    begin
        for (int s = 0; s < tsa_pkg::NUM_SIZES; s++)
        begin
            size_ok[s] = enable_reg[s] && hits.one_back[s]
                         && (!confirm_reg[1] || hits.two_back[s]);
        end

        found      = 1'b0;
        found_size = tsa_pkg::SZ_188;
        priority if (size_ok[tsa_pkg::SZ_188])
        begin
            found      = 1'b1;
            found_size = tsa_pkg::SZ_188;
        end
        else if (size_ok[tsa_pkg::SZ_192])
        begin
            found      = 1'b1;
            found_size = tsa_pkg::SZ_192;
        end
        else if (size_ok[tsa_pkg::SZ_204])
        begin
            found      = 1'b1;
            found_size = tsa_pkg::SZ_204;
        end

        lost = (state_reg == tsa_pkg::ST_LOCK) && (pos_reg == 8'd0) && !is_sync;

        state_next = state_reg;
        size_next  = size_reg;
        pos_next   = pos_reg;
        cur_size   = size_reg;
        cur_pos    = pos_reg;
        pos_inc    = 9'd0;
        produce    = 1'b0;

        if (clear)
        begin
            state_next = tsa_pkg::ST_HUNT;
            size_next  = tsa_pkg::SZ_188;
            pos_next   = '0;
        end
        else if (step)
        begin
            if ((state_reg == tsa_pkg::ST_HUNT || lost) && is_sync && found)
            begin
                cur_size   = found_size;
                cur_pos    = '0;
                size_next  = found_size;
                state_next = tsa_pkg::ST_LOCK;
            end
            else if (state_reg == tsa_pkg::ST_HUNT || lost)
            begin
                state_next = tsa_pkg::ST_HUNT;
            end

            if (state_next == tsa_pkg::ST_LOCK)
            begin
                produce  = cur_pos < 8'(tsa_pkg::OUT_PACKET_BYTES);
                pos_inc  = {1'b0, cur_pos} + 9'd1;
                pos_next = (pos_inc >= {1'b0, tsa_pkg::packet_bytes(cur_size)})
                           ? 8'd0 : pos_inc[7:0];
            end
            else
            begin
                pos_next = '0;
            end
        end

        word.out_byte        = data_byte;
        word.first_of_packet = (cur_pos == 8'd0);
        word.last_of_packet  = (cur_pos == 8'(tsa_pkg::OUT_PACKET_BYTES - 1));
        word.size_code       = cur_size;
    end

endmodule

// ===== rtl/core/ts_packet_sync_aligner.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ts_packet_sync_aligner
// Transport stream sync finder and packet aligner, one byte per cycle.
// ============================================================================
// Input stream: s_tdata carries one raw byte, s_tuser[0] is restart. A
// restart word clears lock, position and history and gives no output.
// Output stream: m_tdata carries a packet byte, m_tlast marks byte 187,
// m_tuser holds first_of_packet (bit 0) and size_code (bits 2:1).
// Only bytes 0..187 of each locked packet are sent; surplus bytes of 192-
// and 204-byte packets and all bytes while hunting are dropped.
// Configuration: cfg_index 0 is confirm_count, 1 is size_enable; always ready.
// Throughput: one input word per cycle. The sync history lives in a memory
// read 188 words back each cycle, with a 16-word tap line for the longer
// spacings. Latency: a result shows on m_tvalid the cycle after its input.
// A single output register sits between the sides: s_tready stays high while
// the register is empty or drained that cycle, so a stalled receiver holds
// the input back after one word. Reset clears control state and the history
// fill count; no clearing pass runs, the block is ready right after reset.
// ============================================================================
module ts_packet_sync_aligner #(
    parameter int HISTORY_DEPTH = tsa_pkg::HISTORY_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tuser,   // restart
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,
    output logic [2:0] m_tuser,   // first_of_packet, size_code[1:0]
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [2:0] cfg_data
);

    tsa_pkg::sync_hits_t hits;
    tsa_pkg::out_word_t  word;
    tsa_pkg::out_word_t  out_reg;
    logic                produce;
    logic                accept;
    logic                step;
    logic                clear;
    logic                is_sync;
    logic                m_valid_reg;

    assign s_tready  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign clear     = accept && s_tuser;
    assign step      = accept && !s_tuser;
    assign is_sync   = (s_tdata == tsa_pkg::SYNC_BYTE);

    tsa_history #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_history (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .clear   (clear),
        .is_sync (is_sync),
        .hits    (hits)
    );

    tsa_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .clear     (clear),
        .is_sync   (is_sync),
        .data_byte (s_tdata),
        .hits      (hits),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .produce   (produce),
        .word      (word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (step && produce)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && produce)
        begin
            out_reg <= word;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg.out_byte;
    assign m_tlast  = out_reg.last_of_packet;
    assign m_tuser  = {out_reg.size_code, out_reg.first_of_packet};

endmodule

// ===== rtl/core/tsa_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tsa_checker
// Port-level checks of the packet aligner, bound to the top level.
// ============================================================================
module tsa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [2:0] m_tuser
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == tsa_pkg::SYNC_BYTE)
        else $error("packet start is not a sync byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tlast && m_tuser[0]))
        else $error("word flagged both first and last");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[2:1] != 2'd3)
        else $error("size code out of range");

endmodule

bind ts_packet_sync_aligner tsa_checker u_tsa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
